/* hw/rtl/apae_pkg.sv */
package apae_pkg;

  localparam int WaitWidth     = 16;
  localparam int FrameLen      = 42;
  localparam int PosWidth      = 6;
  localparam int PosMax        = 63;
  localparam int QueueDepth    = 4;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCntWidth = $clog2(QueueDepth + 1);

  typedef logic [WaitWidth-1:0] wait_t;
  typedef logic [PosWidth-1:0]  pos_t;

  typedef enum logic [2:0] {
    KindStartProbe    = 3'd0,
    KindStartAnnounce = 3'd1,
    KindTick          = 3'd2,
    KindRxByte        = 3'd3,
    KindAbort         = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StatusFrame        = 3'd0,
    StatusProbeClear   = 3'd1,
    StatusConflict     = 3'd2,
    StatusAnnounceDone = 3'd3,
    StatusAborted      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ModeIdle     = 2'd0,
    ModeProbe    = 2'd1,
    ModeAnnounce = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CfgOwnMac        = 3'd0,
    CfgProbeAddress  = 3'd1,
    CfgWaitTicks     = 3'd2,
    CfgProbeTotal    = 3'd3,
    CfgAnnounceTotal = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] probe_address;
    logic [15:0] wait_ticks;
    logic [2:0]  probe_total;
    logic [2:0]  announce_total;
  } cfg_t;

  // A job asks the back end for one frame, one report, or a frame followed by a report.
  // A report of StatusFrame means that no report follows.
  typedef struct packed {
    logic    frame;
    logic    announce;
    status_e report;
  } job_t;

  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(logic [31:0] ip, logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/apae_if.sv */
interface apae_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] rx_data;
  logic       rx_end;

  modport source (output valid, output kind, output rx_data, output rx_end, input ready);
  modport sink (input valid, input kind, input rx_data, input rx_end, output ready);
endinterface

interface apae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_data;
  logic       tx_end;
  logic [2:0] status;

  modport source (output valid, output tx_data, output tx_end, output status, input ready);
  modport sink (input valid, input tx_data, input tx_end, input status, output ready);
endinterface

interface apae_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/apae_front.sv */
module apae_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apae_pkg::cfg_t    cfg_i,
  apae_in_if.sink           evt_i,
  input  logic              q_full_i,
  output logic              push_o,
  output apae_pkg::job_t    job_o
);

  apae_pkg::mode_e mode_q, mode_d;
  logic [2:0]      frames_q, frames_d;
  apae_pkg::wait_t ticks_q, ticks_d;
  apae_pkg::pos_t  pos_q, pos_d;
  logic            match_q, match_d;
  logic            sha_q, sha_d;

  apae_pkg::pos_t  pos_n;
  logic            match_n;
  logic            sha_n;
  apae_pkg::wait_t window;
  logic [2:0]      probe_total;
  logic [2:0]      announce_total;
  logic            accept;

  function automatic logic byte_ok(apae_pkg::pos_t pos, logic [7:0] b, logic [31:0] ip);
    logic ok;
    case (pos)
      6'd12:   ok = (b == 8'h08);
      6'd13:   ok = (b == 8'h06);
      6'd14:   ok = (b == 8'h00);
      6'd15:   ok = (b == 8'h01);
      6'd16:   ok = (b == 8'h08);
      6'd17:   ok = (b == 8'h00);
      6'd18:   ok = (b == 8'h06);
      6'd19:   ok = (b == 8'h04);
      6'd20:   ok = (b == 8'h00);
      6'd21:   ok = (b == 8'h01) || (b == 8'h02);
      6'd28, 6'd29, 6'd30, 6'd31: ok = (b == apae_pkg::ip_byte(ip, pos[1:0]));
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  assign evt_i.ready = !q_full_i;
  assign accept      = evt_i.valid && !q_full_i;

  assign window = (apae_pkg::wait_t'(cfg_i.wait_ticks) == '0) ? apae_pkg::wait_t'(1)
                                                              : apae_pkg::wait_t'(cfg_i.wait_ticks);
  assign probe_total    = (cfg_i.probe_total == 3'd0) ? 3'd1 : cfg_i.probe_total;
  assign announce_total = (cfg_i.announce_total == 3'd0) ? 3'd1 : cfg_i.announce_total;

  // Receive parser: the byte under test updates the match flags before the frame end is judged.
  always_comb begin
    match_n = match_q;
    sha_n   = sha_q;
    pos_n   = pos_q;
    if (pos_q < apae_pkg::pos_t'(apae_pkg::FrameLen)) begin
      if (!byte_ok(pos_q, evt_i.rx_data, cfg_i.probe_address)) begin
        match_n = 1'b0;
      end
      if (pos_q >= 6'd22 && pos_q < 6'd28 &&
          evt_i.rx_data != apae_pkg::mac_byte(cfg_i.own_mac, 3'(pos_q - 6'd22))) begin
        sha_n = 1'b1;
      end
    end
    if (pos_q != apae_pkg::pos_t'(apae_pkg::PosMax)) begin
      pos_n = pos_q + 6'd1;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    frames_d = frames_q;
    ticks_d  = ticks_q;
    pos_d    = pos_q;
    match_d  = match_q;
    sha_d    = sha_q;
    push_o   = 1'b0;
    job_o    = '{frame: 1'b0, announce: 1'b0, report: apae_pkg::StatusFrame};
    if (accept) begin
      unique case (evt_i.kind)
        apae_pkg::KindStartProbe: begin
          mode_d      = apae_pkg::ModeProbe;
          frames_d    = 3'd1;
          ticks_d     = window;
          push_o      = 1'b1;
          job_o.frame = 1'b1;
        end
        apae_pkg::KindStartAnnounce: begin
          mode_d         = apae_pkg::ModeAnnounce;
          frames_d       = 3'd1;
          push_o         = 1'b1;
          job_o.frame    = 1'b1;
          job_o.announce = 1'b1;
          if (announce_total == 3'd1) begin
            mode_d       = apae_pkg::ModeIdle;
            job_o.report = apae_pkg::StatusAnnounceDone;
          end else begin
            ticks_d = window;
          end
        end
        apae_pkg::KindTick: begin
          if (mode_q != apae_pkg::ModeIdle) begin
            if (ticks_q > apae_pkg::wait_t'(1)) begin
              ticks_d = ticks_q - apae_pkg::wait_t'(1);
            end else begin
              ticks_d = '0;
              push_o  = 1'b1;
              if (mode_q == apae_pkg::ModeProbe) begin
                if (frames_q >= probe_total) begin
                  mode_d       = apae_pkg::ModeIdle;
                  job_o.report = apae_pkg::StatusProbeClear;
                end else begin
                  frames_d    = frames_q + 3'd1;
                  ticks_d     = window;
                  job_o.frame = 1'b1;
                end
              end else begin
                frames_d       = frames_q + 3'd1;
                job_o.frame    = 1'b1;
                job_o.announce = 1'b1;
                if (frames_q + 3'd1 >= announce_total) begin
                  mode_d       = apae_pkg::ModeIdle;
                  job_o.report = apae_pkg::StatusAnnounceDone;
                end else begin
                  ticks_d = window;
                end
              end
            end
          end
        end
        apae_pkg::KindRxByte: begin
          if (evt_i.rx_end) begin
            if (mode_q == apae_pkg::ModeProbe &&
                pos_n >= apae_pkg::pos_t'(apae_pkg::FrameLen) && match_n && sha_n) begin
              mode_d       = apae_pkg::ModeIdle;
              ticks_d      = '0;
              push_o       = 1'b1;
              job_o.report = apae_pkg::StatusConflict;
            end
            pos_d   = '0;
            match_d = 1'b1;
            sha_d   = 1'b0;
          end else begin
            pos_d   = pos_n;
            match_d = match_n;
            sha_d   = sha_n;
          end
        end
        apae_pkg::KindAbort: begin
          if (mode_q != apae_pkg::ModeIdle) begin
            mode_d       = apae_pkg::ModeIdle;
            ticks_d      = '0;
            push_o       = 1'b1;
            job_o.report = apae_pkg::StatusAborted;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= apae_pkg::ModeIdle;
      frames_q <= 3'd0;
      ticks_q  <= '0;
      pos_q    <= '0;
      match_q  <= 1'b1;
      sha_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      frames_q <= frames_d;
      ticks_q  <= ticks_d;
      pos_q    <= pos_d;
      match_q  <= match_d;
      sha_q    <= sha_d;
    end
  end

endmodule

/* hw/rtl/apae_queue.sv */
module apae_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  apae_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output apae_pkg::job_t pop_job_o,
  output logic           empty_o
);

  apae_pkg::job_t                        entry_q [apae_pkg::QueueDepth];
  logic [apae_pkg::QueuePtrWidth-1:0]    wr_ptr_q;
  logic [apae_pkg::QueuePtrWidth-1:0]    rd_ptr_q;
  logic [apae_pkg::QueueCntWidth-1:0]    count_q;
  logic                                  do_push;
  logic                                  do_pop;

  assign full_o    = (count_q == apae_pkg::QueueCntWidth'(apae_pkg::QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + apae_pkg::QueuePtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + apae_pkg::QueuePtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + apae_pkg::QueueCntWidth'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - apae_pkg::QueueCntWidth'(1);
      end
    end
  end

endmodule

/* hw/rtl/apae_back.sv */
module apae_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  apae_pkg::cfg_t cfg_i,
  input  logic           q_empty_i,
  input  apae_pkg::job_t q_job_i,
  output logic           pop_o,
  apae_out_if.source     res_o
);

  apae_pkg::job_t  cur_q;
  logic            active_q;
  apae_pkg::pos_t  pos_q;
  logic            out_valid_q;
  logic [7:0]      out_data_q;
  logic            out_end_q;
  apae_pkg::status_e out_status_q;

  logic [7:0]        item_data;
  logic              item_end;
  apae_pkg::status_e item_status;
  logic              last_byte;
  logic              out_load;

  function automatic logic [7:0] frame_byte(apae_pkg::pos_t pos, logic announce,
                                            logic [47:0] mac, logic [31:0] ip);
    logic [7:0] b;
    if (pos < 6'd6) begin
      b = 8'hff;
    end else if (pos < 6'd12) begin
      b = apae_pkg::mac_byte(mac, 3'(pos - 6'd6));
    end else if (pos < 6'd22) begin
      case (pos)
        6'd12:   b = 8'h08;
        6'd13:   b = 8'h06;
        6'd15:   b = 8'h01;
        6'd16:   b = 8'h08;
        6'd18:   b = 8'h06;
        6'd19:   b = 8'h04;
        6'd21:   b = 8'h01;
        default: b = 8'h00;
      endcase
    end else if (pos < 6'd28) begin
      b = apae_pkg::mac_byte(mac, 3'(pos - 6'd22));
    end else if (pos < 6'd32) begin
      b = announce ? apae_pkg::ip_byte(ip, pos[1:0]) : 8'h00;
    end else if (pos < 6'd38) begin
      b = 8'h00;
    end else begin
      b = apae_pkg::ip_byte(ip, 2'(pos - 6'd38));
    end
    return b;
  endfunction

  assign last_byte = (pos_q == apae_pkg::pos_t'(apae_pkg::FrameLen - 1));
  assign out_load  = active_q && (!out_valid_q || res_o.ready);
  assign pop_o     = !active_q && !q_empty_i;

  always_comb begin
    if (cur_q.frame) begin
      item_data   = frame_byte(pos_q, cur_q.announce, cfg_i.own_mac, cfg_i.probe_address);
      item_end    = last_byte;
      item_status = apae_pkg::StatusFrame;
    end else begin
      item_data   = 8'h00;
      item_end    = 1'b0;
      item_status = cur_q.report;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        pos_q    <= '0;
      end else if (out_load) begin
        if (cur_q.frame && !last_byte) begin
          pos_q <= pos_q + 6'd1;
        end else begin
          pos_q <= '0;
          if (!cur_q.frame || cur_q.report == apae_pkg::StatusFrame) begin
            active_q <= 1'b0;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_job_i;
    end else if (out_load && cur_q.frame && last_byte) begin
      cur_q.frame <= 1'b0;
    end
    if (out_load) begin
      out_data_q   <= item_data;
      out_end_q    <= item_end;
      out_status_q <= item_status;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.tx_data = out_data_q;
  assign res_o.tx_end  = out_end_q;
  assign res_o.status  = out_status_q;

endmodule

/* hw/rtl/arp_probe_announce_engine.sv */
// ARP probe and announce engine with address conflict detection.
// The event channel (evt_i) carries commands, timer ticks and received frame bytes. A
// transfer on it is one event; it is taken in the cycle it is offered unless the job queue
// is full, so received bytes and ticks stream at one per cycle.
// The result channel (res_o) carries transmitted frame bytes (42 per frame, tx_end on the
// last) and status reports. Results pass through the job queue, the back end's job register
// and the result register; a frame then streams at one byte per cycle while the receiver
// takes them, and the back end takes the next job from the queue only after finishing the
// current one.
// The configuration channel (cfg_i) is always ready and writes one register per transfer;
// it should only be used while the engine has no results pending.
// The front end keeps the probe state and parses received frames; a four-entry job queue
// lets it keep taking events while the back end serializes frames. When the receiver stalls,
// the result register holds its value, the back end stops, and once the queue fills the
// event channel drops ready.
// Reset clears the engine to idle with an empty queue and restores the register defaults.
module arp_probe_announce_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  apae_cfg_if.sink    cfg_i,
  apae_in_if.sink     evt_i,
  apae_out_if.source  res_o
);

  apae_pkg::cfg_t cfg_q;
  logic           push;
  apae_pkg::job_t push_job;
  logic           q_full;
  logic           q_empty;
  logic           pop;
  apae_pkg::job_t pop_job;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_mac        <= '0;
      cfg_q.probe_address  <= '0;
      cfg_q.wait_ticks     <= 16'd1000;
      cfg_q.probe_total    <= 3'd3;
      cfg_q.announce_total <= 3'd2;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        apae_pkg::CfgOwnMac:        cfg_q.own_mac        <= cfg_i.data;
        apae_pkg::CfgProbeAddress:  cfg_q.probe_address  <= cfg_i.data[31:0];
        apae_pkg::CfgWaitTicks:     cfg_q.wait_ticks     <= cfg_i.data[15:0];
        apae_pkg::CfgProbeTotal:    cfg_q.probe_total    <= cfg_i.data[2:0];
        apae_pkg::CfgAnnounceTotal: cfg_q.announce_total <= cfg_i.data[2:0];
        default: begin
        end
      endcase
    end
  end

  apae_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .evt_i    (evt_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  apae_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  apae_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_job_i   (pop_job),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

/* hw/rtl/apae_checker.sv */
module apae_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] res_tx_data_i,
  input logic       res_tx_end_i,
  input logic [2:0] res_status_i
);

  // A result that is not taken stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable({res_tx_data_i, res_tx_end_i, res_status_i}))
    else $error("result changed while stalled");

  // Status reports carry no frame byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i != apae_pkg::StatusFrame |->
      res_tx_data_i == 8'h00 && !res_tx_end_i)
    else $error("status report carries frame data");

  // Nothing is offered in the first cycle after reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !res_valid_i)
    else $error("result offered right after reset");

  // The configuration port never stalls out of reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind arp_probe_announce_engine apae_checker u_apae_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_ready_i   (cfg_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_tx_data_i (res_o.tx_data),
  .res_tx_end_i  (res_o.tx_end),
  .res_status_i  (res_o.status)
);

/* tb/sv/apae_result_checker.sv */
module apae_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  apae_cfg_if  cfg_i,
  apae_in_if   evt_i,
  apae_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [15:0] WaitTicksReset = 16'd1000;
  localparam logic [79:0] ArpHeader      = 80'h0806_0001_0800_0604_0001;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } tx_rec_t;

  tx_rec_t           tx_expected_q[$];
  apae_pkg::cfg_t    regs;
  apae_pkg::mode_e   mode;
  logic [2:0]        frames_sent;
  apae_pkg::wait_t   ticks_left;
  apae_pkg::pos_t    rx_pos;
  logic              rx_match;
  logic              rx_mac_diff;

  function automatic apae_pkg::wait_t window_len();
    return (apae_pkg::wait_t'(regs.wait_ticks) == '0) ? apae_pkg::wait_t'(1)
                                                       : apae_pkg::wait_t'(regs.wait_ticks);
  endfunction

  function automatic logic [2:0] at_least_one(logic [2:0] t);
    return (t == 3'd0) ? 3'd1 : t;
  endfunction

  function automatic logic [7:0] own_octet(int i);
    return regs.own_mac[8*(5-i) +: 8];
  endfunction

  function automatic logic [7:0] addr_octet(int i);
    return regs.probe_address[8*(3-i) +: 8];
  endfunction

  function automatic logic [7:0] header_octet(int i);
    return ArpHeader[8*(9-i) +: 8];
  endfunction

  function automatic logic [7:0] arp_octet(int i, bit announce);
    logic [7:0] b;
    if (i < 6) b = 8'hff;
    else if (i < 12) b = own_octet(i - 6);
    else if (i < 22) b = header_octet(i - 12);
    else if (i < 28) b = own_octet(i - 22);
    else if (i < 32) b = announce ? addr_octet(i - 28) : 8'h00;
    else if (i < 38) b = 8'h00;
    else b = addr_octet(i - 38);
    return b;
  endfunction

  function automatic bit rx_octet_ok(int pos, logic [7:0] b);
    if (pos == 21) return (b == 8'd1) || (b == 8'd2);
    if (pos >= 12 && pos < 21) return b == header_octet(pos - 12);
    if (pos >= 28 && pos < 32) return b == addr_octet(pos - 28);
    return 1'b1;
  endfunction

  task automatic add_frame(bit announce);
    tx_rec_t r;
    for (int i = 0; i < apae_pkg::FrameLen; i++) begin
      r.data   = arp_octet(i, announce);
      r.last   = (i == apae_pkg::FrameLen - 1);
      r.status = apae_pkg::StatusFrame;
      tx_expected_q.push_back(r);
    end
  endtask

  task automatic add_report(apae_pkg::status_e s);
    tx_rec_t r;
    r.data   = 8'h00;
    r.last   = 1'b0;
    r.status = s;
    tx_expected_q.push_back(r);
  endtask

  task automatic announce_step();
    add_frame(1'b1);
    frames_sent = frames_sent + 3'd1;
    if (frames_sent >= at_least_one(regs.announce_total)) begin
      mode = apae_pkg::ModeIdle;
      add_report(apae_pkg::StatusAnnounceDone);
    end else begin
      ticks_left = window_len();
    end
  endtask

  task automatic advance_engine(logic [2:0] kind, logic [7:0] data, logic last);
    int pos;
    case (kind)
      apae_pkg::KindStartProbe: begin
        mode        = apae_pkg::ModeProbe;
        frames_sent = 3'd1;
        ticks_left  = window_len();
        add_frame(1'b0);
      end
      apae_pkg::KindStartAnnounce: begin
        mode        = apae_pkg::ModeAnnounce;
        frames_sent = 3'd0;
        announce_step();
      end
      apae_pkg::KindTick: begin
        if (mode != apae_pkg::ModeIdle) begin
          if (ticks_left > apae_pkg::wait_t'(1)) begin
            ticks_left = ticks_left - apae_pkg::wait_t'(1);
          end else begin
            ticks_left = '0;
            if (mode == apae_pkg::ModeProbe) begin
              if (frames_sent >= at_least_one(regs.probe_total)) begin
                mode = apae_pkg::ModeIdle;
                add_report(apae_pkg::StatusProbeClear);
              end else begin
                frames_sent = frames_sent + 3'd1;
                ticks_left  = window_len();
                add_frame(1'b0);
              end
            end else begin
              announce_step();
            end
          end
        end
      end
      apae_pkg::KindRxByte: begin
        pos = int'(rx_pos);
        if (pos < apae_pkg::FrameLen) begin
          if (!rx_octet_ok(pos, data)) rx_match = 1'b0;
          if (pos >= 22 && pos < 28 && data != own_octet(pos - 22)) rx_mac_diff = 1'b1;
        end
        if (pos < apae_pkg::PosMax) rx_pos = rx_pos + apae_pkg::pos_t'(1);
        if (last) begin
          if (mode == apae_pkg::ModeProbe && int'(rx_pos) >= apae_pkg::FrameLen &&
              rx_match && rx_mac_diff) begin
            mode       = apae_pkg::ModeIdle;
            ticks_left = '0;
            add_report(apae_pkg::StatusConflict);
          end
          rx_pos      = '0;
          rx_match    = 1'b1;
          rx_mac_diff = 1'b0;
        end
      end
      apae_pkg::KindAbort: begin
        if (mode != apae_pkg::ModeIdle) begin
          mode       = apae_pkg::ModeIdle;
          ticks_left = '0;
          add_report(apae_pkg::StatusAborted);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(tx_rec_t got);
    tx_rec_t want;
    if (tx_expected_q.size() == 0) begin
      if (fail_count_o < 10) begin
        $display("Result with nothing expected: data %h end %b status %0d",
                 got.data, got.last, got.status);
      end
      fail_count_o++;
    end else begin
      want = tx_expected_q.pop_front();
      if (got.data != want.data || got.last != want.last || got.status != want.status) begin
        if (fail_count_o < 10) begin
          $display({"Result mismatch: expected data %h end %b status %0d, ",
                    "got data %h end %b status %0d"},
                   want.data, want.last, want.status, got.data, got.last, got.status);
        end
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.own_mac        = '0;
      regs.probe_address  = '0;
      regs.wait_ticks     = WaitTicksReset;
      regs.probe_total    = 3'd3;
      regs.announce_total = 3'd2;
      mode                = apae_pkg::ModeIdle;
      frames_sent         = 3'd0;
      ticks_left          = '0;
      rx_pos              = '0;
      rx_match            = 1'b1;
      rx_mac_diff         = 1'b0;
      tx_expected_q.delete();
      fail_count_o        = 0;
      pending_o           = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          apae_pkg::CfgOwnMac:        regs.own_mac        = cfg_i.data;
          apae_pkg::CfgProbeAddress:  regs.probe_address  = cfg_i.data[31:0];
          apae_pkg::CfgWaitTicks:     regs.wait_ticks     = cfg_i.data[15:0];
          apae_pkg::CfgProbeTotal:    regs.probe_total    = cfg_i.data[2:0];
          apae_pkg::CfgAnnounceTotal: regs.announce_total = cfg_i.data[2:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        check_result({res_i.tx_data, res_i.tx_end, res_i.status});
      end
      if (evt_i.valid && evt_i.ready) begin
        advance_engine(evt_i.kind, evt_i.rx_data, evt_i.rx_end);
      end
      pending_o = tx_expected_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;

  localparam int          CycleLimit   = 1000000;
  localparam int          PhaseEvents  = 16;
  localparam int          SettleCycles = 16;
  localparam int          RxLenMax     = 50;
  localparam logic [2:0]  KindUnusedLo = 3'd5;
  localparam logic [2:0]  KindUnusedHi = 3'd7;
  localparam logic [79:0] ArpHeader    = 80'h0806_0001_0800_0604_0001;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          pending;
  int          idle_pct;
  int          stall_pct;
  int          events_sent;
  logic [47:0] own_mac_q;
  logic [31:0] probe_ip_q;

  apae_cfg_if cfg_bus ();
  apae_in_if  evt_bus ();
  apae_out_if res_bus ();

  arp_probe_announce_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .evt_i  (evt_bus),
    .res_o  (res_bus)
  );

  apae_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_bus),
    .evt_i        (evt_bus),
    .res_i        (res_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("arp_probe_announce_engine test failed");
    $finish;
  end

  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_bus.ready <= (int'($urandom_range(99)) >= stall_pct);
    end
  end

  function automatic logic [7:0] rand_octet();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_event(logic [2:0] kind, logic [7:0] data, logic last);
    while (int'($urandom_range(99)) < idle_pct) begin
      evt_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt_bus.valid   <= 1'b1;
    evt_bus.kind    <= kind;
    evt_bus.rx_data <= data;
    evt_bus.rx_end  <= last;
    do @(posedge clk_i); while (!evt_bus.ready);
    @(negedge clk_i);
    if (kind <= apae_pkg::KindAbort) events_sent++;
  endtask

  task automatic send_cmd(apae_pkg::kind_e kind);
    send_event(kind, rand_octet(), 1'($urandom_range(1)));
  endtask

  task automatic cfg_xfer(apae_pkg::cfg_idx_e idx, logic [47:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
  endtask

  // Narrow registers get random upper bits so that truncation is exercised.
  task automatic set_config(logic [47:0] mac, logic [31:0] ip, logic [15:0] wt,
                            logic [2:0] pt, logic [2:0] at);
    logic [47:0] junk;
    junk = {16'($urandom), 32'($urandom)};
    cfg_xfer(apae_pkg::CfgOwnMac, mac);
    cfg_xfer(apae_pkg::CfgProbeAddress, {junk[47:32], ip});
    cfg_xfer(apae_pkg::CfgWaitTicks, {junk[47:16], wt});
    cfg_xfer(apae_pkg::CfgProbeTotal, {junk[47:3], pt});
    cfg_xfer(apae_pkg::CfgAnnounceTotal, {junk[47:3], at});
    cfg_bus.valid <= 1'b0;
    own_mac_q  = mac;
    probe_ip_q = ip;
  endtask

  task automatic settle();
    evt_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic send_rx_frame();
    logic [7:0] octets [70];
    int         len;
    int         flavor;
    int         pos;
    logic       same_mac;
    len    = apae_pkg::FrameLen;
    flavor = $urandom_range(9);
    for (int i = 0; i < 70; i++) octets[i] = rand_octet();
    for (int i = 0; i < 10; i++) octets[12+i] = ArpHeader[8*(9-i) +: 8];
    octets[21] = 8'($urandom_range(1, 2));
    for (int i = 0; i < 4; i++) octets[28+i] = probe_ip_q[8*(3-i) +: 8];
    if (flavor == 4 || flavor == 5) begin
      for (int i = 0; i < 6; i++) octets[22+i] = own_mac_q[8*(5-i) +: 8];
      if (flavor == 5) begin
        pos = $urandom_range(5);
        octets[22+pos] = octets[22+pos] ^ 8'($urandom_range(1, 255));
      end
    end else begin
      same_mac = 1'b1;
      for (int i = 0; i < 6; i++) begin
        if (octets[22+i] != own_mac_q[8*(5-i) +: 8]) same_mac = 1'b0;
      end
      if (same_mac) octets[27] = octets[27] ^ 8'h01;
    end
    if (flavor == 6) begin
      pos = $urandom_range(13);
      pos = (pos < 10) ? 12 + pos : 18 + pos;
      octets[pos] = octets[pos] ^ 8'($urandom_range(1, 255));
    end else if (flavor == 7) begin
      len = $urandom_range(1, apae_pkg::FrameLen - 1);
    end else if (flavor == 8) begin
      len = $urandom_range(apae_pkg::FrameLen + 1, RxLenMax);
    end else if (flavor == 9) begin
      for (int i = 12; i < 32; i++) octets[i] = rand_octet();
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) send_cmd(apae_pkg::KindTick);
      send_event(apae_pkg::KindRxByte, octets[i], i == len - 1);
    end
  endtask

  task automatic probe_session(int target);
    int roll;
    int steps;
    send_cmd(apae_pkg::KindStartProbe);
    steps = $urandom_range(1, 25);
    while (steps > 0 && events_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 60) send_cmd(apae_pkg::KindTick);
      else if (roll < 94) send_rx_frame();
      else send_cmd(apae_pkg::KindAbort);
      steps--;
    end
  endtask

  task automatic announce_session(int target);
    int roll;
    int steps;
    send_cmd(apae_pkg::KindStartAnnounce);
    steps = $urandom_range(0, 20);
    while (steps > 0 && events_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 85) send_cmd(apae_pkg::KindTick);
      else if (roll < 92) send_rx_frame();
      else send_cmd(apae_pkg::KindAbort);
      steps--;
    end
  endtask

  task automatic run_phase(int idle, int stall, logic [47:0] mac, logic [31:0] ip,
                           logic [15:0] wt, logic [2:0] pt, logic [2:0] at);
    int target;
    int roll;
    settle();
    set_config(mac, ip, wt, pt, at);
    idle_pct  = idle;
    stall_pct = stall;
    target    = events_sent + PhaseEvents;
    while (events_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        probe_session(target);
      end else if (roll < 85) begin
        announce_session(target);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_event(3'($urandom_range(7)), rand_octet(), 1'($urandom_range(1)));
        end
      end
    end
    send_cmd(apae_pkg::KindAbort);
    settle();
  endtask

  initial begin
    idle_pct        = 0;
    stall_pct       = 0;
    events_sent     = 0;
    own_mac_q       = '0;
    probe_ip_q      = '0;
    evt_bus.valid   = 1'b0;
    evt_bus.kind    = apae_pkg::KindTick;
    evt_bus.rx_data = 8'h00;
    evt_bus.rx_end  = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = apae_pkg::CfgOwnMac;
    cfg_bus.data    = '0;
    rst_ni          = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Register defaults: long window, so the probe is cut short by abort.
    send_event(apae_pkg::KindStartProbe, 8'h00, 1'b0);
    send_event(apae_pkg::KindTick, 8'hff, 1'b1);
    send_event(apae_pkg::KindAbort, 8'h5a, 1'b0);
    send_event(apae_pkg::KindAbort, 8'ha5, 1'b1);
    send_event(apae_pkg::KindTick, 8'h00, 1'b0);
    send_event(apae_pkg::KindStartAnnounce, 8'hff, 1'b0);
    send_event(apae_pkg::KindStartProbe, 8'h0f, 1'b1);
    send_event(KindUnusedLo, 8'hf0, 1'b1);
    send_event(KindUnusedHi, 8'h3c, 1'b0);
    send_event(apae_pkg::KindAbort, 8'h00, 1'b0);
    settle();

    set_config(48'hffff_ffff_ffff, 32'hffff_ffff, 16'd1, 3'd1, 3'd1);
    send_cmd(apae_pkg::KindStartAnnounce);
    send_cmd(apae_pkg::KindStartProbe);
    send_cmd(apae_pkg::KindTick);
    settle();

    set_config(48'h0, 32'h0, 16'd0, 3'd0, 3'd0);
    send_cmd(apae_pkg::KindStartAnnounce);
    send_cmd(apae_pkg::KindStartProbe);
    send_cmd(apae_pkg::KindTick);
    settle();

    set_config({16'($urandom), 32'($urandom)}, 32'($urandom), 16'hffff, 3'd7, 3'd7);
    send_cmd(apae_pkg::KindStartProbe);
    send_cmd(apae_pkg::KindTick);
    send_cmd(apae_pkg::KindTick);
    send_cmd(apae_pkg::KindStartAnnounce);
    send_cmd(apae_pkg::KindTick);
    send_cmd(apae_pkg::KindAbort);

    run_phase(0, 0, {16'($urandom), 32'($urandom)}, 32'($urandom), 16'd1, 3'd1, 3'd1);
    run_phase(63, 0, 48'hffff_ffff_ffff, 32'($urandom), 16'd3, 3'd7, 3'd7);
    run_phase(0, 63, 48'h0, 32'h0, 16'd0, 3'd0, 3'd0);
    run_phase(37, 37, {16'($urandom), 32'($urandom)}, 32'hffff_ffff, 16'd2, 3'd3, 3'd2);

    if (fail_count == 0 && pending == 0) begin
      $display("arp_probe_announce_engine test passed");
    end else begin
      $display("arp_probe_announce_engine test failed");
    end
    $finish;
  end

endmodule

/* arp_probe_announce_engine.f */
hw/rtl/apae_pkg.sv
hw/rtl/apae_if.sv
hw/rtl/apae_front.sv
hw/rtl/apae_queue.sv
hw/rtl/apae_back.sv
hw/rtl/arp_probe_announce_engine.sv
hw/rtl/apae_checker.sv
tb/sv/apae_result_checker.sv
tb/sv/tb_top.sv
